// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
// No dependencies; files that assert pull this in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge while reset is low.
`define CQIR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check a property at each rising edge, reset included.
`define CQIR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/cqir_pkg.sv =====
// Shared types and constants of the circular queue with indexed read.
// No dependencies.
package cqir_pkg;

   // Default sizes of the slot store
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths
   localparam int POS_W  = 5;   // capacity, head and tail positions
   localparam int IDX_W  = 4;   // slot index of a get request
   localparam int KIND_W = 2;   // request kind

   // Capacity after reset
   localparam int CAP_RESET = (DEPTH_DEFAULT < 16) ? DEPTH_DEFAULT : 16;

   // Request kinds
   localparam logic [KIND_W-1:0] REQ_PUSH = 2'd0;
   localparam logic [KIND_W-1:0] REQ_POP  = 2'd1;
   localparam logic [KIND_W-1:0] REQ_PEEK = 2'd2;
   localparam logic [KIND_W-1:0] REQ_GET  = 2'd3;

   // Result queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int LEVEL_W     = 3;

   // Status that travels with each result beat
   typedef struct packed {
      logic ok;
      logic is_empty;
      logic is_full;
   } flags_type;

endpackage

// ===== hw/rtl/circular_queue_with_indexed_read_top.sv =====
// Top level of the circular queue with indexed read.
// Depends on cqir_pkg, cqir_ram, cqir_front and cqir_back.
//
// Usage:
//   Requests enter on req_* (valid/ready): push, pop, peek at head, or get
//   a physical slot. Each request yields exactly one response on rsp_*
//   (valid/ready) with ok, the read word and the empty and full flags as
//   they stand after the request.
//   The slot RAM read and the status of a request are registered at the
//   accepting edge; the response then passes through the result queue
//   and the output register, and is held back while the receiver stalls.
//   Throughput: one request per cycle with req_ready high; head and tail
//   update as a request is taken, so the next one follows immediately.
//   A four-beat result queue sits between front and back; when the
//   receiver stalls it fills and req_ready drops until room returns.
//   csr_wr_en writes the capacity (0 is taken as 1, large values are
//   clipped to the store depth) and empties the queue; write it only
//   while no response is pending. Store contents are kept.
//   Reset empties the queue and sets capacity to min(DEPTH, 16); the
//   slot store is not cleared, and only pushed slots are ever read.
module circular_queue_with_indexed_read_top #(
   parameter int DEPTH      = cqir_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cqir_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [cqir_pkg::POS_W-1:0]  csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [cqir_pkg::KIND_W-1:0] req_type,
   input  logic [DATA_WIDTH-1:0]       req_push_data,
   input  logic [cqir_pkg::IDX_W-1:0]  req_slot_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_ok,
   output logic [DATA_WIDTH-1:0]       rsp_read_data,
   output logic                        rsp_is_empty,
   output logic                        rsp_is_full
);

   localparam int AW = $clog2(DEPTH);

   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   logic [DATA_WIDTH-1:0]        ram_wr_data;
   logic [AW-1:0]                ram_rd_addr;
   logic [DATA_WIDTH-1:0]        ram_rd_data;
   logic [cqir_pkg::LEVEL_W-1:0] queue_level;
   logic                         enq_valid;
   cqir_pkg::flags_type          enq_flags;
   logic [DATA_WIDTH-1:0]        enq_data;

   cqir_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cqir_front #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_push_data  (req_push_data),
      .req_slot_index (req_slot_index),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .queue_level    (queue_level),
      .enq_valid      (enq_valid),
      .enq_flags      (enq_flags),
      .enq_data       (enq_data)
   );

   cqir_back #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .enq_valid     (enq_valid),
      .enq_flags     (enq_flags),
      .enq_data      (enq_data),
      .queue_level   (queue_level),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ok        (rsp_ok),
      .rsp_read_data (rsp_read_data),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_is_full   (rsp_is_full)
   );

endmodule

// ===== hw/rtl/cqir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cqir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cqir_front.sv =====
// Front end: accepts requests, keeps capacity, head and tail, drives the slot RAM.
// Depends on cqir_pkg and assert_macros.svh; feeds the result queue in cqir_back.
`include "assert_macros.svh"

module cqir_front #(
   parameter int DEPTH      = cqir_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cqir_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [cqir_pkg::POS_W-1:0]       csr_wr_data,
   // requests
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cqir_pkg::KIND_W-1:0]      req_type,
   input  logic [DATA_WIDTH-1:0]            req_push_data,
   input  logic [cqir_pkg::IDX_W-1:0]       req_slot_index,
   // slot RAM
   output logic                             ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]         ram_wr_addr,
   output logic [DATA_WIDTH-1:0]            ram_wr_data,
   output logic [$clog2(DEPTH)-1:0]         ram_rd_addr,
   input  logic [DATA_WIDTH-1:0]            ram_rd_data,
   // result queue
   input  logic [cqir_pkg::LEVEL_W-1:0]     queue_level,
   output logic                             enq_valid,
   output cqir_pkg::flags_type              enq_flags,
   output logic [DATA_WIDTH-1:0]            enq_data
);

   localparam int AW      = $clog2(DEPTH);
   localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
   localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;
   localparam int PW      = cqir_pkg::POS_W;

   logic [PW-1:0] cap_ff, cap_in;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_rd_ff, s1_rd_in;
   cqir_pkg::flags_type s1_flags_ff, s1_flags_in;

   logic          accept;
   logic          empty_now;
   logic          full_now;
   logic          live;
   logic          ok;
   logic [PW-1:0] cap_wr;
   logic [PW-1:0] idx_pos;

   function automatic logic empty_of(input logic [PW-1:0] h, input logic [PW-1:0] t,
                                     input logic [PW-1:0] c);
      return (h == c) || (t == c);
   endfunction

   function automatic logic full_of(input logic [PW-1:0] h, input logic [PW-1:0] t,
                                    input logic [PW-1:0] c);
      logic wrap_end;
      logic behind;
      wrap_end = (h == '0) && (t == PW'(c - 1'b1));
      behind   = (h != '0) && (t == PW'(h - 1'b1));
      return !empty_of(h, t, c) && (wrap_end || behind);
   endfunction

   // Leave room in the queue for the staged beat and this one
   assign req_ready = (queue_level + cqir_pkg::LEVEL_W'(s1_valid_ff))
                      < cqir_pkg::LEVEL_W'(cqir_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   assign empty_now = empty_of(head_ff, tail_ff, cap_ff);
   assign full_now  = full_of(head_ff, tail_ff, cap_ff);
   assign idx_pos   = PW'(req_slot_index);

   // Live region from head to tail, wrapping at capacity
   always_comb begin
      if (empty_now || (idx_pos >= cap_ff)) begin
         live = 1'b0;
      end else if (head_ff <= tail_ff) begin
         live = (idx_pos >= head_ff) && (idx_pos <= tail_ff);
      end else begin
         live = (idx_pos <= tail_ff) || (idx_pos >= head_ff);
      end
   end

   // Clamp a written capacity into 1 .. min(DEPTH, 31)
   always_comb begin
      if (csr_wr_data == '0) begin
         cap_wr = PW'(1);
      end else if (32'(csr_wr_data) > CAP_MAX) begin
         cap_wr = PW'(CAP_MAX);
      end else begin
         cap_wr = csr_wr_data;
      end
   end

   // Update positions and classify the request
   always_comb begin
      cap_in  = cap_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      ok      = 1'b0;
      unique case (req_type)
         cqir_pkg::REQ_PUSH: begin
            if (!full_now) begin
               ok = 1'b1;
               if (empty_now) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (tail_ff == PW'(cap_ff - 1'b1)) begin
                  tail_in = '0;
               end else begin
                  tail_in = PW'(tail_ff + 1'b1);
               end
            end
         end
         cqir_pkg::REQ_POP: begin
            if (!empty_now) begin
               ok = 1'b1;
               if (head_ff == tail_ff) begin
                  head_in = cap_ff;
                  tail_in = cap_ff;
               end else if (head_ff == PW'(cap_ff - 1'b1)) begin
                  head_in = '0;
               end else begin
                  head_in = PW'(head_ff + 1'b1);
               end
            end
         end
         cqir_pkg::REQ_PEEK: begin
            ok = !empty_now;
         end
         cqir_pkg::REQ_GET: begin
            ok = live;
         end
      endcase
      if (!accept) begin
         head_in = head_ff;
         tail_in = tail_ff;
      end
      // A configuration write empties the queue
      if (csr_wr_en) begin
         cap_in  = cap_wr;
         head_in = cap_wr;
         tail_in = cap_wr;
      end
   end

   // Stage the result status until the RAM read data returns
   assign s1_valid_in          = accept;
   assign s1_rd_in             = ok && ((req_type == cqir_pkg::REQ_PEEK)
                                        || (req_type == cqir_pkg::REQ_GET));
   assign s1_flags_in.ok       = ok;
   assign s1_flags_in.is_empty = empty_of(head_in, tail_in, cap_ff);
   assign s1_flags_in.is_full  = full_of(head_in, tail_in, cap_ff);

   // Slot RAM access
   assign ram_wr_en   = accept && (req_type == cqir_pkg::REQ_PUSH) && !full_now;
   assign ram_wr_addr = AW'(tail_in);
   assign ram_wr_data = req_push_data;
   assign ram_rd_addr = (req_type == cqir_pkg::REQ_PEEK) ? AW'(head_ff) : AW'(req_slot_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= PW'(CAP_RST);
         head_ff     <= PW'(CAP_RST);
         tail_ff     <= PW'(CAP_RST);
         s1_valid_ff <= 1'b0;
      end else begin
         cap_ff      <= cap_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rd_ff    <= s1_rd_in;
         s1_flags_ff <= s1_flags_in;
      end
   end

   // Hand the staged beat to the queue
   assign enq_valid = s1_valid_ff;
   assign enq_flags = s1_flags_ff;
   assign enq_data  = s1_rd_ff ? ram_rd_data : '0;

   `CQIR_ASSERT(a_empty_pair, clock, reset, (head_ff == cap_ff) == (tail_ff == cap_ff), "head and tail disagree on empty")
   `CQIR_ASSERT(a_cap_range, clock, reset, (cap_ff != '0) && (32'(cap_ff) <= CAP_MAX), "capacity out of range")
   `CQIR_ASSERT(a_pos_range, clock, reset, (head_ff <= cap_ff) && (tail_ff <= cap_ff), "position beyond capacity")

endmodule

// ===== hw/rtl/cqir_back.sv =====
// Back end: short result queue and the output register of the response channel.
// Depends on cqir_pkg and assert_macros.svh; fed by cqir_front.
`include "assert_macros.svh"

module cqir_back #(
   parameter int DATA_WIDTH = cqir_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // from the front end
   input  logic                         enq_valid,
   input  cqir_pkg::flags_type          enq_flags,
   input  logic [DATA_WIDTH-1:0]        enq_data,
   output logic [cqir_pkg::LEVEL_W-1:0] queue_level,
   // responses
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_ok,
   output logic [DATA_WIDTH-1:0]        rsp_read_data,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full
);

   localparam int QD = cqir_pkg::QUEUE_DEPTH;
   localparam int QW = cqir_pkg::QPTR_W;
   localparam int LW = cqir_pkg::LEVEL_W;

   cqir_pkg::flags_type   q_flags_ff [QD];
   logic [DATA_WIDTH-1:0] q_data_ff  [QD];
   logic [QW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]         count_ff, count_in;
   logic                  out_valid_ff, out_valid_in;
   cqir_pkg::flags_type   out_flags_ff;
   logic [DATA_WIDTH-1:0] out_data_ff;
   logic                  deq;

   // Advance the queue into the output register when that register frees up
   assign deq          = (count_ff != '0) && (!out_valid_ff || rsp_ready);
   assign wr_ptr_in    = enq_valid ? QW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in    = deq ? QW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign count_in     = LW'(count_ff + LW'(enq_valid) - LW'(deq));
   assign out_valid_in = deq || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Store incoming beats
   always_ff @(posedge clock) begin
      if (enq_valid) begin
         q_flags_ff[wr_ptr_ff] <= enq_flags;
         q_data_ff[wr_ptr_ff]  <= enq_data;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (deq) begin
         out_flags_ff <= q_flags_ff[rd_ptr_ff];
         out_data_ff  <= q_data_ff[rd_ptr_ff];
      end
   end

   assign queue_level   = count_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_ok        = out_flags_ff.ok;
   assign rsp_read_data = out_data_ff;
   assign rsp_is_empty  = out_flags_ff.is_empty;
   assign rsp_is_full   = out_flags_ff.is_full;

   `CQIR_ASSERT(a_no_overflow, clock, reset, !(enq_valid && (count_ff == LW'(QD)) && !deq), "result queue overflow")
   `CQIR_ASSERT(a_level_range, clock, reset, count_ff <= LW'(QD), "result queue level out of range")
   `CQIR_ASSERT(a_fail_zero, clock, reset, (out_valid_ff && !out_flags_ff.ok) |-> (out_data_ff == '0), "failed request carries data")

endmodule

// ===== dv/cqir_checker.sv =====
// Scoreboard for the circular queue with indexed read: tracks ring state,
// predicts each response beat and compares it with what the block returns.
// Depends on cqir_pkg for field widths and request kind codes.
module cqir_checker #(
   parameter int SLOTS = cqir_pkg::DEPTH_DEFAULT,
   parameter int DW    = cqir_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [cqir_pkg::POS_W-1:0]  csr_wr_data,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [cqir_pkg::KIND_W-1:0] req_type,
   input  logic [DW-1:0]               req_push_data,
   input  logic [cqir_pkg::IDX_W-1:0]  req_slot_index,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_ok,
   input  logic [DW-1:0]               rsp_read_data,
   input  logic                        rsp_is_empty,
   input  logic                        rsp_is_full,
   output int                          fail_count,
   output int                          pending,
   output int                          beats_checked,
   output int                          wraps_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic          ok;
      logic [DW-1:0] word;
      logic          empty;
      logic          full;
   } queue_status_type;

   // Mirror of the ring: slot words, head, tail and live capacity
   logic [DW-1:0]              slot_words [SLOTS];
   logic [cqir_pkg::POS_W-1:0] head_q;
   logic [cqir_pkg::POS_W-1:0] tail_q;
   logic [cqir_pkg::POS_W-1:0] cap_q;

   queue_status_type expected_status [$];

   function automatic bit ring_empty();
      return (head_q == cap_q) || (tail_q == cap_q);
   endfunction

   function automatic bit ring_full();
      bit wrap_end;
      bit behind;
      wrap_end = (head_q == 0) && (tail_q == cap_q - 1'b1);
      behind   = (head_q != 0) && (tail_q == head_q - 1'b1);
      return !ring_empty() && (wrap_end || behind);
   endfunction

   // Live region runs from head to tail, wrapping at capacity
   function automatic bit slot_live(logic [cqir_pkg::IDX_W-1:0] idx);
      logic [cqir_pkg::POS_W-1:0] pos;
      pos = cqir_pkg::POS_W'(idx);
      if (ring_empty() || pos >= cap_q)
         return 0;
      if (head_q <= tail_q)
         return (pos >= head_q) && (pos <= tail_q);
      return (pos <= tail_q) || (pos >= head_q);
   endfunction

   // Clip the written capacity and empty the ring
   function automatic void load_capacity(logic [cqir_pkg::POS_W-1:0] value);
      logic [cqir_pkg::POS_W-1:0] v;
      v = value;
      if (v == 0)
         v = 1;
      if (v > SLOTS)
         v = cqir_pkg::POS_W'(SLOTS);
      cap_q  = v;
      head_q = v;
      tail_q = v;
   endfunction

   // Apply one request to the mirror and return the status it produces
   function automatic queue_status_type serve_request(logic [cqir_pkg::KIND_W-1:0] kind,
                                                      logic [DW-1:0] word,
                                                      logic [cqir_pkg::IDX_W-1:0] idx);
      queue_status_type s;
      s = '0;
      case (kind)
         cqir_pkg::REQ_PUSH: begin
            if (!ring_full()) begin
               if (ring_empty()) begin
                  head_q = 0;
                  tail_q = 0;
               end else if (tail_q == cap_q - 1'b1) begin
                  tail_q = 0;
                  wraps_seen++;
               end else begin
                  tail_q = tail_q + 1'b1;
               end
               slot_words[tail_q] = word;
               s.ok = 1;
            end
         end
         cqir_pkg::REQ_POP: begin
            if (!ring_empty()) begin
               if (head_q == tail_q) begin
                  head_q = cap_q;
                  tail_q = cap_q;
               end else if (head_q == cap_q - 1'b1) begin
                  head_q = 0;
               end else begin
                  head_q = head_q + 1'b1;
               end
               s.ok = 1;
            end
         end
         cqir_pkg::REQ_PEEK: begin
            if (!ring_empty()) begin
               s.word = slot_words[head_q];
               s.ok   = 1;
            end
         end
         cqir_pkg::REQ_GET: begin
            if (slot_live(idx)) begin
               s.word = slot_words[idx];
               s.ok   = 1;
            end
         end
         default: ;
      endcase
      s.empty = ring_empty();
      s.full  = ring_full();
      return s;
   endfunction

   // Check response beats, then track config writes and accepted requests
   always @(posedge clock) begin
      queue_status_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++)
            slot_words[i] = '0;
         load_capacity(cqir_pkg::POS_W'(cqir_pkg::CAP_RESET));
         expected_status.delete();
         fail_count    = 0;
         beats_checked = 0;
         wraps_seen    = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_count++;
            end else begin
               want = expected_status.pop_front();
               beats_checked++;
               if (rsp_ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, rsp_ok);
                  fail_count++;
               end
               if (rsp_read_data !== want.word) begin
                  $error("read_data: expected 0x%08h, got 0x%08h", want.word, rsp_read_data);
                  fail_count++;
               end
               if (rsp_is_empty !== want.empty) begin
                  $error("is_empty: expected %0d, got %0d", want.empty, rsp_is_empty);
                  fail_count++;
               end
               if (rsp_is_full !== want.full) begin
                  $error("is_full: expected %0d, got %0d", want.full, rsp_is_full);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en)
            load_capacity(csr_wr_data);
         if (req_valid && req_ready)
            expected_status.push_back(serve_request(req_type, req_push_data, req_slot_index));
      end
      pending = expected_status.size();
   end

endmodule

// ===== dv/tb.sv =====
// Top of the queue testbench: clock, reset, request and response drivers,
// capacity phases, watchdog and verdict.
// Depends on cqir_pkg, the block's top level and cqir_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW             = cqir_pkg::DATA_WIDTH_DEFAULT;
   localparam int PHASE_ITEMS    = 120;
   localparam int HOLD_CYCLES    = 40;
   localparam int IDLE_LIMIT     = 500;
   localparam int NUM_PHASES     = 14;
   localparam int QUIET_PHASES   = 2;
   localparam int CAP_PLAN [NUM_PHASES] =
      '{1, 16, 0, 31, 5, 17, 3, 2, 8, 12, 4, 15, 7, 16};

   logic                          clock;
   logic                          reset;
   logic                          csr_wr_en;
   logic [cqir_pkg::POS_W-1:0]    csr_wr_data;
   logic                          req_valid;
   logic                          req_ready;
   logic [cqir_pkg::KIND_W-1:0]   req_type;
   logic [DW-1:0]                 req_push_data;
   logic [cqir_pkg::IDX_W-1:0]    req_slot_index;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic                          rsp_ok;
   logic [DW-1:0]                 rsp_read_data;
   logic                          rsp_is_empty;
   logic                          rsp_is_full;

   int fail_count;
   int pending;
   int beats_checked;
   int wraps_seen;

   bit gaps_on;
   int hold_asks;
   int items_sent;
   int settings_used;
   int idle_run;

   circular_queue_with_indexed_read_top uut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_push_data  (req_push_data),
      .req_slot_index (req_slot_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_read_data  (rsp_read_data),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full)
   );

   cqir_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_push_data  (req_push_data),
      .req_slot_index (req_slot_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_read_data  (rsp_read_data),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .fail_count     (fail_count),
      .pending        (pending),
      .beats_checked  (beats_checked),
      .wraps_seen     (wraps_seen)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Offer one request beat and hold it until accepted; enter and leave at a falling edge
   task automatic issue(input logic [cqir_pkg::KIND_W-1:0] kind, input logic [DW-1:0] word,
                        input logic [cqir_pkg::IDX_W-1:0] idx);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid      = 1;
      req_type       = kind;
      req_push_data  = word;
      req_slot_index = idx;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   // Drain outstanding responses, then write a new capacity
   task automatic set_capacity(input logic [cqir_pkg::POS_W-1:0] value);
      req_valid = 0;
      while (pending != 0) @(negedge clock);
      csr_wr_en   = 1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 0;
      settings_used++;
   endtask

   // Response side: random stall bursts, plus one long hold-off on request
   initial begin
      int hold_served;
      hold_served = 0;
      rsp_ready   = 0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_served) begin
            hold_served++;
            rsp_ready = 0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_ready = 1;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_ready = 0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_ready = 1;
         end else begin
            rsp_ready = 1;
         end
      end
   end

   // Abort when no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_run <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_run <= 0;
      end else if (idle_run + 1 >= IDLE_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   initial begin
      int cap_eff;
      int run_len;
      int pct;
      bit filling;
      logic [cqir_pkg::KIND_W-1:0] kind;
      logic [DW-1:0] word;
      logic [cqir_pkg::IDX_W-1:0] idx;

      reset          = 1;
      csr_wr_en      = 0;
      csr_wr_data    = '0;
      req_valid      = 0;
      req_type       = cqir_pkg::REQ_PUSH;
      req_push_data  = '0;
      req_slot_index = '0;
      gaps_on        = 1;
      hold_asks      = 0;
      items_sent     = 0;
      settings_used  = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Empty queue at reset capacity: every read fails, then two pushes, a peek and gets in and out of the live region
      issue(cqir_pkg::REQ_POP,  '0, '0);
      issue(cqir_pkg::REQ_PEEK, '0, '0);
      issue(cqir_pkg::REQ_GET,  '0, 4'd0);
      issue(cqir_pkg::REQ_PUSH, '0, '0);
      issue(cqir_pkg::REQ_PUSH, '1, '1);
      issue(cqir_pkg::REQ_PEEK, '0, '0);
      issue(cqir_pkg::REQ_GET,  '0, 4'd1);
      issue(cqir_pkg::REQ_GET,  '0, 4'd15);

      // Two-slot ring: fill, overflow, out-of-range get, wrap tail and head
      set_capacity(5'd2);
      issue(cqir_pkg::REQ_PUSH, 32'hA5A5_0001, '0);
      issue(cqir_pkg::REQ_PUSH, 32'h5A5A_0002, '0);
      issue(cqir_pkg::REQ_PUSH, 32'hDEAD_BEEF, '0);
      issue(cqir_pkg::REQ_PEEK, '0, '0);
      issue(cqir_pkg::REQ_GET,  '0, 4'd0);
      issue(cqir_pkg::REQ_GET,  '0, 4'd1);
      issue(cqir_pkg::REQ_GET,  '0, 4'd2);
      issue(cqir_pkg::REQ_POP,  '0, '0);
      issue(cqir_pkg::REQ_GET,  '0, 4'd0);
      issue(cqir_pkg::REQ_PUSH, 32'h0000_FFFF, '0);
      issue(cqir_pkg::REQ_GET,  '0, 4'd0);
      issue(cqir_pkg::REQ_PEEK, '0, '0);
      issue(cqir_pkg::REQ_POP,  '0, '0);
      issue(cqir_pkg::REQ_POP,  '0, '0);
      issue(cqir_pkg::REQ_POP,  '0, '0);

      // Random phases, one capacity each, alternating fill and drain runs
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph >= NUM_PHASES - QUIET_PHASES)
            gaps_on = 0;
         set_capacity(cqir_pkg::POS_W'(CAP_PLAN[ph]));
         cap_eff = (CAP_PLAN[ph] == 0) ? 1 :
                   (CAP_PLAN[ph] > cqir_pkg::DEPTH_DEFAULT) ? cqir_pkg::DEPTH_DEFAULT :
                   CAP_PLAN[ph];
         filling = 1;
         run_len = $urandom_range(8, 40);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 1 && n == 20)
               hold_asks++;
            if (run_len == 0) begin
               filling = !filling;
               run_len = $urandom_range(8, 40);
            end
            run_len--;
            pct = $urandom_range(0, 99);
            if (filling)
               kind = (pct < 55) ? cqir_pkg::REQ_PUSH : (pct < 70) ? cqir_pkg::REQ_POP :
                      (pct < 80) ? cqir_pkg::REQ_PEEK : cqir_pkg::REQ_GET;
            else
               kind = (pct < 15) ? cqir_pkg::REQ_PUSH : (pct < 65) ? cqir_pkg::REQ_POP :
                      (pct < 78) ? cqir_pkg::REQ_PEEK : cqir_pkg::REQ_GET;
            case ($urandom_range(0, 9))
               0:       word = '0;
               1:       word = '1;
               default: word = $urandom;
            endcase
            if ($urandom_range(0, 9) < 7)
               idx = cqir_pkg::IDX_W'($urandom_range(0, cap_eff - 1));
            else
               idx = cqir_pkg::IDX_W'($urandom_range(0, 15));
            issue(kind, word, idx);
         end
      end

      // Let the last responses come back, then give the verdict
      req_valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      $display("Sent %0d requests across %0d capacity settings (0, 1, 16 and clipped values).",
               items_sent, settings_used);
      $display("Checked %0d response beats; tail wrapped %0d times.", beats_checked, wraps_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cqir_pkg.sv
hw/rtl/cqir_ram.sv
hw/rtl/cqir_front.sv
hw/rtl/cqir_back.sv
hw/rtl/circular_queue_with_indexed_read_top.sv
dv/cqir_checker.sv
dv/tb.sv
